@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/irq_pkg.sv @@
`timescale 1ns / 1ps

package irq_pkg;

   localparam int CMD_W     = 3;
   localparam int VALUE_W   = 32;
   localparam int INDEX_W   = 4;
   localparam int STATUS_W  = 1;
   localparam int LENGTH_W  = 5;
   localparam int SIZE_LOG_W = 3;

   localparam logic [SIZE_LOG_W-1:0] SIZE_LOG2_RESET = 3'd4;

   typedef logic [CMD_W-1:0] cmd_code_type;

   localparam cmd_code_type CMD_PUSH   = 3'd0;
   localparam cmd_code_type CMD_POP    = 3'd1;
   localparam cmd_code_type CMD_READ   = 3'd2;
   localparam cmd_code_type CMD_REMOVE = 3'd3;
   localparam cmd_code_type CMD_SEARCH = 3'd4;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RDWAIT,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } irq_state_type;

   typedef struct packed {
      logic latch;
      logic push_wr;
      logic rd_item;
      logic take_data;
      logic pop_commit;
      logic fail;
      logic scan_start;
      logic scan_step;
      logic shift_from_idx;
      logic shift_from_hit;
      logic shift_step;
      logic remove_commit;
      logic publish;
   } irq_ctl_type;

   typedef struct packed {
      cmd_code_type cmd;
      logic         can_push;
      logic         not_empty;
      logic         idx_ok;
      logic         hit;
      logic         miss;
      logic         shift_done;
      logic         out_free;
   } irq_sts_type;

endpackage

@@ rtl/core/irq_ram.sv @@
`timescale 1ns / 1ps

module irq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/irq_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module irq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  irq_pkg::irq_sts_type sts,
   output irq_pkg::irq_ctl_type ctl
);

   irq_pkg::irq_state_type state_ff;
   irq_pkg::irq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= irq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         irq_pkg::ST_IDLE: begin
            if (req_valid) state_in = irq_pkg::ST_EXEC;
         end
         irq_pkg::ST_EXEC: begin
            unique case (sts.cmd)
               irq_pkg::CMD_POP:
                  state_in = sts.not_empty ? irq_pkg::ST_RDWAIT : irq_pkg::ST_DONE;
               irq_pkg::CMD_READ:
                  state_in = sts.idx_ok ? irq_pkg::ST_RDWAIT : irq_pkg::ST_DONE;
               irq_pkg::CMD_REMOVE:
                  state_in = sts.idx_ok ? irq_pkg::ST_SHIFT : irq_pkg::ST_DONE;
               irq_pkg::CMD_SEARCH:
                  state_in = sts.not_empty ? irq_pkg::ST_SCAN : irq_pkg::ST_DONE;
               default:
                  state_in = irq_pkg::ST_DONE;
            endcase
         end
         irq_pkg::ST_RDWAIT: begin
            state_in = irq_pkg::ST_DONE;
         end
         irq_pkg::ST_SCAN: begin
            priority if (sts.hit) begin
               state_in = irq_pkg::ST_SHIFT;
            end else if (sts.miss) begin
               state_in = irq_pkg::ST_DONE;
            end else begin
               state_in = irq_pkg::ST_SCAN;
            end
         end
         irq_pkg::ST_SHIFT: begin
            if (sts.shift_done) state_in = irq_pkg::ST_DONE;
         end
         irq_pkg::ST_DONE: begin
            if (sts.out_free) state_in = irq_pkg::ST_IDLE;
         end
         default: state_in = irq_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         irq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ctl.latch = req_valid;
         end
         irq_pkg::ST_EXEC: begin
            unique case (sts.cmd)
               irq_pkg::CMD_PUSH: begin
                  ctl.push_wr = sts.can_push;
                  ctl.fail    = !sts.can_push;
               end
               irq_pkg::CMD_POP: begin
                  ctl.rd_item = sts.not_empty;
                  ctl.fail    = !sts.not_empty;
               end
               irq_pkg::CMD_READ: begin
                  ctl.rd_item = sts.idx_ok;
                  ctl.fail    = !sts.idx_ok;
               end
               irq_pkg::CMD_REMOVE: begin
                  ctl.shift_from_idx = sts.idx_ok;
                  ctl.fail           = !sts.idx_ok;
               end
               irq_pkg::CMD_SEARCH: begin
                  ctl.scan_start = sts.not_empty;
                  ctl.fail       = !sts.not_empty;
               end
               default: ctl.fail = 1'b1;
            endcase
         end
         irq_pkg::ST_RDWAIT: begin
            ctl.take_data  = 1'b1;
            ctl.pop_commit = (sts.cmd == irq_pkg::CMD_POP);
         end
         irq_pkg::ST_SCAN: begin
            priority if (sts.hit) begin
               ctl.shift_from_hit = 1'b1;
            end else if (sts.miss) begin
               ctl.fail = 1'b1;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         irq_pkg::ST_SHIFT: begin
            ctl.remove_commit = sts.shift_done;
            ctl.shift_step    = !sts.shift_done;
         end
         irq_pkg::ST_DONE: begin
            ctl.publish = sts.out_free;
         end
         default: ctl = '0;
      endcase
   end

   `ASSERT_IMPL(a_shift_cmd, clock, reset, state_ff == irq_pkg::ST_SHIFT,
      sts.cmd == irq_pkg::CMD_REMOVE || sts.cmd == irq_pkg::CMD_SEARCH)
   `ASSERT_NEXT(a_publish_idle, clock, reset, ctl.publish, state_ff == irq_pkg::ST_IDLE)

endmodule

@@ rtl/core/irq_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module irq_dp #(
   parameter int MAX_ENTRIES = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [irq_pkg::SIZE_LOG_W-1:0]    csr_write_data,
   input  irq_pkg::cmd_code_type             req_command,
   input  logic [irq_pkg::VALUE_W-1:0]       req_value,
   input  logic [irq_pkg::INDEX_W-1:0]       req_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [irq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [irq_pkg::VALUE_W-1:0]       rsp_data,
   output logic [irq_pkg::LENGTH_W-1:0]      rsp_length,
   input  irq_pkg::irq_ctl_type              ctl,
   output irq_pkg::irq_sts_type              sts
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int SW = ((AW > CW) ? AW : CW) + 1;
   localparam int XW = CW + irq_pkg::INDEX_W;
   localparam int OW = (DATA_WIDTH < irq_pkg::VALUE_W) ? DATA_WIDTH : irq_pkg::VALUE_W;

   function automatic logic [CW-1:0] cap_of(input logic [irq_pkg::SIZE_LOG_W-1:0] lg);
      logic [7:0] pw;
      pw = 8'd1 << lg;
      if (32'(pw) > MAX_ENTRIES) return CW'(MAX_ENTRIES);
      return CW'(pw);
   endfunction

   // head + logical, wrapped once at the capacity
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                             input logic [CW-1:0] l,
                                             input logic [CW-1:0] c);
      logic [SW-1:0] s;
      s = SW'(h) + SW'(l);
      if (s >= SW'(c)) s = s - SW'(c);
      return AW'(s);
   endfunction

   logic [CW-1:0]          cap_ff, cap_in;
   logic [AW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          cursor_ff, cursor_in;
   logic                   pend_ff, pend_in;
   logic [CW-1:0]          cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]          wr_slot_ff, wr_slot_in;
   irq_pkg::cmd_code_type  cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0]  value_ff, value_in;
   logic [irq_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic                   res_status_ff, res_status_in;
   logic [DATA_WIDTH-1:0]  res_data_ff, res_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0]  rsp_data_ff, rsp_data_in;
   logic [CW-1:0]          rsp_length_ff, rsp_length_in;

   logic [CW-1:0]          cursor_inc;
   logic                   more_scan;
   logic                   more_shift;
   logic [CW-1:0]          rd_log;
   logic [AW-1:0]          rd_slot;
   logic [AW-1:0]          push_slot;
   logic [AW-1:0]          cur_slot;
   logic [AW-1:0]          head_next;
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [DATA_WIDTH-1:0]  ram_wr_data;
   logic                   ram_rd_en;
   logic [DATA_WIDTH-1:0]  ram_rd_data;
   logic                   hit;

   assign cursor_inc = cursor_ff + CW'(1);
   assign more_scan  = cursor_ff < count_ff;
   assign more_shift = cursor_inc < count_ff;

   always_comb begin
      priority if (ctl.rd_item) begin
         rd_log = (cmd_ff == irq_pkg::CMD_POP) ? '0 : CW'(idx_ff);
      end else if (ctl.scan_step) begin
         rd_log = cursor_ff;
      end else begin
         rd_log = cursor_inc;
      end
   end

   assign rd_slot   = slot_of(head_ff, rd_log, cap_ff);
   assign push_slot = slot_of(head_ff, count_ff, cap_ff);
   assign cur_slot  = slot_of(head_ff, cursor_ff, cap_ff);
   assign head_next = slot_of(head_ff, CW'(1), cap_ff);

   assign ram_wr_en   = ctl.push_wr | (ctl.shift_step & pend_ff);
   assign ram_wr_addr = ctl.push_wr ? push_slot : wr_slot_ff;
   assign ram_wr_data = ctl.push_wr ? value_ff : ram_rd_data;
   assign ram_rd_en   = ctl.rd_item | (ctl.scan_step & more_scan) |
                        (ctl.shift_step & more_shift);

   irq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_slot),
      .rd_data (ram_rd_data)
   );

   assign hit = pend_ff && (ram_rd_data == value_ff);

   always_comb begin
      sts            = '0;
      sts.cmd        = cmd_ff;
      sts.can_push   = count_ff < cap_ff;
      sts.not_empty  = count_ff != '0;
      sts.idx_ok     = XW'(idx_ff) < XW'(count_ff);
      sts.hit        = hit;
      sts.miss       = !hit && !more_scan;
      sts.shift_done = !pend_ff && !more_shift;
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      cap_in        = cap_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      pend_in       = pend_ff;
      cmp_idx_in    = cmp_idx_ff;
      wr_slot_in    = wr_slot_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_length_in = rsp_length_ff;

      if (csr_write_en) begin
         cap_in   = cap_of(csr_write_data);
         head_in  = '0;
         count_in = '0;
      end
      if (ctl.latch) begin
         cmd_in   = req_command;
         value_in = DATA_WIDTH'(req_value[OW-1:0]);
         idx_in   = req_index;
      end
      if (ctl.push_wr) begin
         count_in      = count_ff + CW'(1);
         res_status_in = irq_pkg::STATUS_OK;
         res_data_in   = '0;
      end
      if (ctl.take_data) begin
         res_status_in = irq_pkg::STATUS_OK;
         res_data_in   = ram_rd_data;
      end
      if (ctl.pop_commit) begin
         head_in  = head_next;
         count_in = count_ff - CW'(1);
      end
      if (ctl.fail) begin
         res_status_in = irq_pkg::STATUS_FAIL;
         res_data_in   = '0;
      end
      if (ctl.scan_start) begin
         cursor_in = '0;
         pend_in   = 1'b0;
      end
      if (ctl.scan_step) begin
         cursor_in  = cursor_inc;
         pend_in    = more_scan;
         cmp_idx_in = cursor_ff;
      end
      if (ctl.shift_from_idx) begin
         cursor_in = CW'(idx_ff);
         pend_in   = 1'b0;
      end
      if (ctl.shift_from_hit) begin
         cursor_in = cmp_idx_ff;
         pend_in   = 1'b0;
      end
      if (ctl.shift_step) begin
         pend_in = more_shift;
         if (more_shift) begin
            cursor_in  = cursor_inc;
            wr_slot_in = cur_slot;
         end
      end
      if (ctl.remove_commit) begin
         count_in      = count_ff - CW'(1);
         res_status_in = irq_pkg::STATUS_OK;
         res_data_in   = '0;
      end
      if (ctl.publish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_data_in   = res_data_ff;
         rsp_length_in = count_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= cap_of(irq_pkg::SIZE_LOG2_RESET);
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff     <= cursor_in;
      cmp_idx_ff    <= cmp_idx_in;
      wr_slot_ff    <= wr_slot_in;
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = irq_pkg::VALUE_W'(rsp_data_ff[OW-1:0]);
   assign rsp_length = irq_pkg::LENGTH_W'(rsp_length_ff);

   `ASSERT_IMPL(a_count_cap, clock, reset, 1'b1, count_ff <= cap_ff)
   `ASSERT_IMPL(a_head_cap, clock, reset, 1'b1, SW'(head_ff) < SW'(cap_ff))
   `ASSERT_IMPL(a_publish_free, clock, reset, ctl.publish, !rsp_valid_ff || rsp_ready)

endmodule

@@ rtl/core/indexed_ring_queue.sv @@
// A request goes from IDLE to EXEC, then to DONE for push and for a command refused at once;
// pop and read pass RDWAIT, removal by index passes SHIFT, and search passes SCAN, then SHIFT
// on a hit; the SCAN and SHIFT steps grow with the stored words. rsp_valid rises on leaving DONE.
// The shared single-write, single-read entry RAM sets the removal time:
// the search reads one entry per cycle, the gap close moves one per cycle.
// One transaction in flight; req_ready rises in the same cycle as rsp_valid.
// Synchronous active-high reset: queue empty, capacity min(16, MAX_ENTRIES), no result pending.
`timescale 1ns / 1ps

module indexed_ring_queue #(
   parameter int MAX_ENTRIES = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [irq_pkg::SIZE_LOG_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [irq_pkg::CMD_W-1:0]       req_command,
   input  logic [irq_pkg::VALUE_W-1:0]     req_value,
   input  logic [irq_pkg::INDEX_W-1:0]     req_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [irq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [irq_pkg::VALUE_W-1:0]     rsp_data,
   output logic [irq_pkg::LENGTH_W-1:0]    rsp_length
);

   irq_pkg::irq_ctl_type ctl;
   irq_pkg::irq_sts_type sts;

   irq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   irq_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_command    (req_command),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_data       (rsp_data),
      .rsp_length     (rsp_length),
      .ctl            (ctl),
      .sts            (sts)
   );

endmodule
